// ===== sv/osd_pkg.sv =====
package osd_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_SWAP   = 3'd2,
    OP_ROT_TB = 3'd3,
    OP_ROT_BT = 3'd4
  } op_kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_SHORT = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SWAP_LAST
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic ld_op;
    logic rd_en;
    logic exec;
    logic swap_first;
    logic swap_last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic swap_ok;
  } dp_status_t;

endpackage

// ===== sv/osd_ctrl.sv =====
module osd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  osd_pkg::dp_status_t dp_status,
  output osd_pkg::dp_cmd_t    dp_cmd
);

  osd_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= osd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dp_cmd    = '0;
    in_stall  = 1'b1;
    case (state_r)
      osd_pkg::S_IDLE: begin
        // hold the input off while reset is applied
        in_stall      = !rst_n;
        dp_cmd.ld_op  = in_valid && rst_n;
        if (in_valid && rst_n) begin
          state_nxt = osd_pkg::S_READ;
        end
      end
      osd_pkg::S_READ: begin
        dp_cmd.rd_en = 1'b1;
        state_nxt    = osd_pkg::S_EXEC;
      end
      osd_pkg::S_EXEC: begin
        // swap writes the lower slot first; no result yet
        if (dp_status.swap_ok) begin
          dp_cmd.swap_first = 1'b1;
          state_nxt         = osd_pkg::S_SWAP_LAST;
        end else if (dp_status.out_free) begin
          dp_cmd.exec = 1'b1;
          state_nxt   = osd_pkg::S_IDLE;
        end
      end
      osd_pkg::S_SWAP_LAST: begin
        if (dp_status.out_free) begin
          dp_cmd.swap_last = 1'b1;
          state_nxt        = osd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = osd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/osd_dp.sv =====
module osd_dp #(
  parameter int CAPACITY = osd_pkg::CAPACITY_DEF,
  localparam int PW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  input  logic [2:0]                        in_kind,
  input  logic signed [osd_pkg::DATA_W-1:0] in_push_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic signed [osd_pkg::DATA_W-1:0] out_top_value,
  output logic [CW-1:0]                     out_depth,
  input  osd_pkg::dp_cmd_t                  dp_cmd,
  output osd_pkg::dp_status_t               dp_status
);

  localparam int SW = $clog2(2 * CAPACITY);
  localparam int DW = osd_pkg::DATA_W;

  logic [DW-1:0] mem [CAPACITY];

  logic          queue_mode_r;
  logic [2:0]    kind_r;
  logic [DW-1:0] val_r;
  logic [DW-1:0] rdata_r;
  logic [DW-1:0] top_r, top_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic              out_valid_r;
  osd_pkg::status_t  out_status_r;
  logic [DW-1:0]     out_top_r;
  logic [CW-1:0]     out_depth_r;

  logic              we;
  logic [PW-1:0]     waddr;
  logic [DW-1:0]     wdata;
  logic [PW-1:0]     raddr;
  osd_pkg::status_t  stat;
  logic              load_out;

  logic [PW-1:0] slot1, slot_cnt, slot_last, slot_up;
  logic          full, two_plus;

  // ring slot lying off places below the top
  function automatic logic [PW-1:0] slot_at(input logic [PW-1:0] p, input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(off);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return s[PW-1:0];
  endfunction

  assign slot1     = slot_at(ptr_r, CW'(1));
  assign slot_cnt  = slot_at(ptr_r, cnt_r);
  assign slot_last = slot_at(ptr_r, cnt_r - CW'(1));
  assign slot_up   = (ptr_r == '0) ? PW'(CAPACITY - 1) : ptr_r - PW'(1);
  assign full      = (cnt_r == CW'(CAPACITY));
  assign two_plus  = (cnt_r >= CW'(2));

  assign raddr = (kind_r == osd_pkg::OP_ROT_BT) ? slot_last : slot1;

  assign dp_status.out_free = !out_valid_r || !out_stall;
  assign dp_status.swap_ok  = (kind_r == osd_pkg::OP_SWAP) && two_plus;

  always_comb begin
    we       = 1'b0;
    waddr    = ptr_r;
    wdata    = top_r;
    ptr_nxt  = ptr_r;
    cnt_nxt  = cnt_r;
    top_nxt  = top_r;
    stat     = osd_pkg::STAT_OK;
    load_out = dp_cmd.exec || dp_cmd.swap_last;
    if (dp_cmd.exec) begin
      case (kind_r)
        osd_pkg::OP_PUSH: begin
          if (full) begin
            stat = osd_pkg::STAT_FULL;
          end else if (queue_mode_r) begin
            we      = 1'b1;
            waddr   = slot_cnt;
            wdata   = val_r;
            cnt_nxt = cnt_r + CW'(1);
            if (cnt_r == '0) begin
              top_nxt = val_r;
            end
          end else begin
            we      = 1'b1;
            waddr   = slot_up;
            wdata   = val_r;
            ptr_nxt = slot_up;
            cnt_nxt = cnt_r + CW'(1);
            top_nxt = val_r;
          end
        end
        osd_pkg::OP_POP: begin
          if (cnt_r == '0) begin
            stat = osd_pkg::STAT_EMPTY;
          end else begin
            ptr_nxt = slot1;
            cnt_nxt = cnt_r - CW'(1);
            top_nxt = rdata_r;
          end
        end
        osd_pkg::OP_SWAP: begin
          stat = osd_pkg::STAT_SHORT;
        end
        osd_pkg::OP_ROT_TB: begin
          if (two_plus) begin
            we      = 1'b1;
            waddr   = slot_cnt;
            wdata   = top_r;
            ptr_nxt = slot1;
            top_nxt = rdata_r;
          end
        end
        osd_pkg::OP_ROT_BT: begin
          if (two_plus) begin
            we      = 1'b1;
            waddr   = slot_up;
            wdata   = rdata_r;
            ptr_nxt = slot_up;
            top_nxt = rdata_r;
          end
        end
        default: begin
        end
      endcase
    end
    if (dp_cmd.swap_first) begin
      we    = 1'b1;
      waddr = slot1;
      wdata = top_r;
    end
    if (dp_cmd.swap_last) begin
      we      = 1'b1;
      waddr   = ptr_r;
      wdata   = rdata_r;
      top_nxt = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (dp_cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.ld_op) begin
      kind_r <= in_kind;
      val_r  <= in_push_value;
    end
    top_r <= top_nxt;
    if (load_out) begin
      out_status_r <= stat;
      out_top_r    <= (cnt_nxt == '0) ? '0 : top_nxt;
      out_depth_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_mode_r <= 1'b0;
      ptr_r        <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        queue_mode_r <= cfg_wdata;
      end
      ptr_r <= ptr_nxt;
      cnt_r <= cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_top_value = out_top_r;
  assign out_depth     = out_depth_r;

endmodule

// ===== sv/operand_stack_deque.sv =====
// Operand stack for a stack-machine interpreter: a bounded ring of CAPACITY
// signed 32-bit entries with a top pointer and an entry count.
// Input channel (in_valid / in_stall): one beat is one operation, in_kind
// selects push, pop, swap, rotate top to bottom or rotate bottom to top,
// in_push_value is used by push only.
// Result channel (out_valid / out_stall): one beat per operation carrying
// out_status (ok, empty, too short, full), the new top value (0 when empty)
// and the new depth.
// cfg_we / cfg_wdata write queue_mode: 0 push adds at top, 1 at bottom.
// Sequence: an operation is accepted in the idle cycle, reads one ring entry
// in the next, and commits and loads the output register in the execute state
// once the output register is free. A valid swap adds a last write state, as
// it needs two writes through the single memory write port. A new operation
// is accepted only after the previous one has committed.
// A result waiting in the output register does not block acceptance; only
// the commit of the following operation holds while out_stall is high.
// Reset (rst_n low, synchronous) stalls the input, empties the stack, clears
// queue_mode and drops any pending result; ring contents are left as is.
module operand_stack_deque #(
  parameter int CAPACITY = osd_pkg::CAPACITY_DEF,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_kind,
  input  logic signed [osd_pkg::DATA_W-1:0] in_push_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic signed [osd_pkg::DATA_W-1:0] out_top_value,
  output logic [CW-1:0]                     out_depth
);

  // command and status between sequencer and datapath
  osd_pkg::dp_cmd_t    dp_cmd;
  osd_pkg::dp_status_t dp_status;

  osd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  // ring memory, pointers, cached top entry and output register
  osd_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_kind       (in_kind),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_top_value (out_top_value),
    .out_depth     (out_depth),
    .dp_cmd        (dp_cmd),
    .dp_status     (dp_status)
  );

endmodule
